/* sv/apm_pkg.sv */
package apm_pkg;

    localparam int MAX_LEVELS   = 8;
    localparam int PATTERN_BITS = 64;
    localparam int ALPHABET     = 128;

    localparam int NUM_CELLS = MAX_LEVELS + 1;
    localparam int ADDR_W    = $clog2(ALPHABET);
    localparam int LEN_IDX_W = $clog2(PATTERN_BITS);
    localparam int TOP_W     = $clog2(NUM_CELLS);

    localparam int OP_W    = 2;
    localparam int SYM_W   = 7;
    localparam int MASK_W  = 64;
    localparam int CNT_W   = 32;
    localparam int ERR_W   = 4;
    localparam int LEN_W   = 7;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [CIDX_W-1:0] REG_MAX_ERRORS     = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

    typedef logic [PATTERN_BITS-1:0] vec_t;

    typedef struct packed {
        logic vld;
        vec_t acc;
        vec_t old_below;
        vec_t new_below;
        vec_t shifted_below;
    } link_t;

endpackage

/* sv/apm_ram.sv */
module apm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/apm_cell.sv */
module apm_cell import apm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  clear,
    input  logic  active,
    input  link_t link_in,
    output link_t link_out
);

    vec_t  vec_reg;
    vec_t  shifted_here;
    vec_t  cur;
    link_t link_reg;
    link_t link_next;

    assign shifted_here = {vec_reg[PATTERN_BITS-2:0], 1'b1};
    assign cur = link_in.old_below
               | {link_in.new_below[PATTERN_BITS-2:0], 1'b0}
               | link_in.shifted_below
               | (shifted_here & link_in.acc);

    always_comb begin
        if (active) begin
            link_next.vld           = link_in.vld;
            link_next.acc           = link_in.acc;
            link_next.old_below     = vec_reg;
            link_next.new_below     = cur;
            link_next.shifted_below = shifted_here;
        end else begin
            link_next = link_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_reg  <= '0;
            link_reg <= '0;
        end else begin
            if (clear) begin
                vec_reg <= '0;
            end else if (link_in.vld && active) begin
                vec_reg <= cur;
            end
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

/* sv/approximate_pattern_matcher_top.sv */
// Approximate pattern matcher, shift-and with up to max_errors (at most MAX_LEVELS) edit errors.
// Input stream s_*: s_tuser is the operation (write table entry, text symbol,
// restart text); s_tdata carries the symbol and the class mask. A restart
// clears the level vectors, position and count.
// Each text symbol produces one transfer on m_*: m_tuser is the match flag,
// m_tdata the 1-based text position and the running match count.
// Registers are written over cfg_* (index 0 max_errors, 1 pattern_length); the user
// must write them only while no text symbol is in flight. The block does not enforce this.
// A text symbol runs through a chain of NUM_CELLS level cells, one level per
// cycle; the table read, each cell and the hit flag are registered, and the
// next item is taken only once the result has entered the output register,
// so a new text symbol is not accepted before the last one is through.
// Reset clears the symbol table (per-entry valid bits), the level vectors,
// the counters and the registers to max_errors 0, pattern_length 1.
// When m_tready is low the result is held in the output register; a new
// item is still taken, and a further text result waits until it drains.
module approximate_pattern_matcher_top import apm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,   // symbol[6:0], class_mask[70:7], zero
    input  logic [OP_W-1:0]      s_tuser,   // operation[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // match_position[31:0], match_count[63:32]
    output logic                 m_tuser,   // match_found[0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CIDX_W-1:0]    cfg_index,
    input  logic [CDATA_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [ERR_W-1:0]  max_errors_reg;
    logic [LEN_W-1:0]  pattern_length_reg;
    logic [ALPHABET-1:0] valid_reg;
    logic              sel_valid_reg;
    logic              lookup_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_tvalid_reg;
    logic              m_found_reg;
    logic [CNT_W-1:0]  m_pos_reg;
    logic [CNT_W-1:0]  m_cnt_reg;

    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  sym;
    logic [MASK_W-1:0] cls;
    logic              in_alpha;
    logic              accept;
    logic              do_write;
    logic              do_text;
    logic              do_restart;
    logic              out_free;
    logic              emit;
    vec_t              rdata;
    vec_t              acc;
    logic [TOP_W-1:0]  top;
    logic [LEN_IDX_W-1:0] len_idx;
    logic [NUM_CELLS-1:0] active;
    link_t             links [NUM_CELLS+1];

    assign op  = s_tuser;
    assign sym = s_tdata[SYM_W-1:0];
    assign cls = s_tdata[SYM_W+MASK_W-1:SYM_W];

    assign in_alpha   = (32'(sym) < ALPHABET);
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign do_write   = accept && (op == OP_WRITE) && in_alpha;
    assign do_text    = accept && (op == OP_TEXT);
    assign do_restart = accept && (op == OP_RESTART);

    assign cfg_ready = 1'b1;

    apm_ram #(
        .WIDTH (PATTERN_BITS),
        .DEPTH (ALPHABET)
    ) u_table (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (sym[ADDR_W-1:0]),
        .wdata (cls[PATTERN_BITS-1:0]),
        .re    (do_text),
        .raddr (sym[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign acc = sel_valid_reg ? rdata : '0;

    always_comb begin
        if (32'(max_errors_reg) > MAX_LEVELS) begin
            top = TOP_W'(MAX_LEVELS);
        end else begin
            top = TOP_W'(max_errors_reg);
        end
        if (pattern_length_reg == '0) begin
            len_idx = '0;
        end else if (32'(pattern_length_reg) > PATTERN_BITS) begin
            len_idx = LEN_IDX_W'(PATTERN_BITS - 1);
        end else begin
            len_idx = LEN_IDX_W'(pattern_length_reg - 1'b1);
        end
    end

    assign links[0].vld           = lookup_reg;
    assign links[0].acc           = acc;
    assign links[0].old_below     = '0;
    assign links[0].new_below     = '0;
    assign links[0].shifted_below = '0;

    for (genvar d = 0; d < NUM_CELLS; d++) begin : g_cell
        assign active[d] = (TOP_W'(d) <= top);
        apm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clear    (do_restart),
            .active   (active[d]),
            .link_in  (links[d]),
            .link_out (links[d+1])
        );
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = (state_reg == ST_FINISH) && out_free;

    always_comb begin
        pos_next = (pos_reg == CNT_MAX) ? pos_reg : pos_reg + 1'b1;
        cnt_next = (hit_reg && cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (do_text) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (links[NUM_CELLS].vld) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            max_errors_reg     <= '0;
            pattern_length_reg <= LEN_W'(1);
            valid_reg          <= '0;
            sel_valid_reg      <= 1'b0;
            lookup_reg         <= 1'b0;
            hit_reg            <= 1'b0;
            pos_reg            <= '0;
            cnt_reg            <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg  <= state_next;
            lookup_reg <= do_text;
            if (do_text) begin
                sel_valid_reg <= in_alpha && valid_reg[sym[ADDR_W-1:0]];
            end
            if (do_write) begin
                valid_reg[sym[ADDR_W-1:0]] <= 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAX_ERRORS:     max_errors_reg     <= cfg_data[ERR_W-1:0];
                    REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (links[NUM_CELLS].vld) begin
                hit_reg <= links[NUM_CELLS].new_below[len_idx];
            end
            if (do_restart) begin
                pos_reg <= '0;
                cnt_reg <= '0;
            end else if (emit) begin
                pos_reg <= pos_next;
                cnt_reg <= cnt_next;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_found_reg <= hit_reg;
            m_pos_reg   <= pos_next;
            m_cnt_reg   <= cnt_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {m_cnt_reg, m_pos_reg};

endmodule

/* test/tb.sv */
module tb;
    import apm_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
    localparam logic [CIDX_W-1:0] REG_UNUSED   = 2'd2;
    localparam int                DRAIN_CYCLES = 24;
    localparam int                RANDOM_ITEMS = 1300;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] position;
        logic [CNT_W-1:0] count;
    } match_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [71:0]        s_tdata   = '0;   // symbol[6:0], class_mask[70:7], zero
    logic [OP_W-1:0]    s_tuser   = '0;   // operation[1:0]
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [63:0]        m_tdata;          // match_position[31:0], match_count[63:32]
    logic               m_tuser;          // match_found[0]
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CDATA_W-1:0] cfg_data  = '0;

    vec_t             sym_table [ALPHABET];
    vec_t             levels [NUM_CELLS];
    logic [CNT_W-1:0] text_pos;
    logic [CNT_W-1:0] match_cnt;
    logic [ERR_W-1:0] err_limit;
    logic [LEN_W-1:0] pat_len_reg;
    match_t           predicted_matches [$];

    int fail_count = 0;
    int items_sent = 0;
    bit tx_idle    = 1'b1;
    bit rx_idle    = 1'b1;
    int rx_hold    = 0;
    int rx_stall   = 0;

    logic [SYM_W-1:0] alpha [8];
    int               alpha_size = 2;
    int               pat_idx [PATTERN_BITS];
    int               pat_size = 1;
    int               cursor = 0;

    approximate_pattern_matcher_top u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_length(logic [LEN_W-1:0] len);
        if (len == 0) return 1;
        if (len > PATTERN_BITS) return PATTERN_BITS;
        return int'(len);
    endfunction

    function automatic void clear_text();
        foreach (levels[i]) levels[i] = '0;
        text_pos  = '0;
        match_cnt = '0;
    endfunction

    function automatic match_t bitap_step(logic [SYM_W-1:0] sym);
        int     top;
        int     len;
        int     d;
        vec_t   acc;
        vec_t   old_below;
        vec_t   shifted_below;
        vec_t   new_below;
        vec_t   old_here;
        vec_t   shifted_here;
        match_t r;
        top = (err_limit > MAX_LEVELS) ? MAX_LEVELS : int'(err_limit);
        len = eff_length(pat_len_reg);
        acc = sym_table[sym];
        old_below     = levels[0];
        shifted_below = (old_below << 1) | vec_t'(1);
        new_below     = shifted_below & acc;
        levels[0]     = new_below;
        for (d = 1; d <= top; d++) begin
            old_here     = levels[d];
            shifted_here = (old_here << 1) | vec_t'(1);
            new_below    = old_below | (new_below << 1) | shifted_below
                         | (shifted_here & acc);
            levels[d]     = new_below;
            old_below     = old_here;
            shifted_below = shifted_here;
        end
        if (text_pos != CNT_MAX) text_pos++;
        if (new_below[len-1] && match_cnt != CNT_MAX) match_cnt++;
        r.found    = new_below[len-1];
        r.position = text_pos;
        r.count    = match_cnt;
        return r;
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                             logic [MASK_W-1:0] mask);
        int gap;
        gap = tx_idle ? idle_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, mask, sym};
        do @(posedge aclk); while (!s_tready);
        case (op)
            OP_WRITE:   sym_table[sym] = mask;
            OP_TEXT:    predicted_matches.push_back(bitap_step(sym));
            OP_RESTART: clear_text();
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (predicted_matches.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAX_ERRORS:     err_limit   = data[ERR_W-1:0];
            REG_PATTERN_LENGTH: pat_len_reg = data;
            default: ;
        endcase
    endtask

    task automatic load_pattern(int len);
        vec_t mask;
        alpha_size = $urandom_range(2, 6);
        pat_size   = len;
        cursor     = 0;
        for (int j = 0; j < alpha_size; j++)
            alpha[j] = SYM_W'($urandom_range(0, ALPHABET-1));
        for (int p = 0; p < pat_size; p++) pat_idx[p] = $urandom_range(0, alpha_size-1);
        for (int j = 0; j < alpha_size; j++) begin
            mask = '0;
            for (int p = 0; p < pat_size; p++)
                if (pat_idx[p] == j) mask[p] = 1'b1;
            if ($urandom_range(0, 9) == 0) mask |= {$urandom, $urandom};
            send_item(OP_WRITE, alpha[j], mask);
        end
    endtask

    // walk the pattern with occasional substitutions, skips and filler
    function automatic logic [SYM_W-1:0] next_text_symbol();
        int               r;
        logic [SYM_W-1:0] sym;
        r = $urandom_range(0, 99);
        if (r < 10) return SYM_W'($urandom_range(0, ALPHABET-1));
        if (r < 18) return alpha[$urandom_range(0, alpha_size-1)];
        if (r < 22) cursor++;
        if (cursor >= pat_size) cursor = 0;
        if (r < 28) sym = alpha[$urandom_range(0, alpha_size-1)];
        else sym = alpha[pat_idx[cursor]];
        cursor = (cursor + 1) % pat_size;
        return sym;
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_item(OP_UNUSED, SYM_W'($urandom), {$urandom, $urandom});
        end else begin
            items_sent++;
            if (r < 7) send_item(OP_WRITE, SYM_W'($urandom), {$urandom, $urandom});
            else if (r < 9) send_item(OP_RESTART, SYM_W'($urandom), {$urandom, $urandom});
            else send_item(OP_TEXT, next_text_symbol(), {$urandom, $urandom});
        end
    endtask

    task automatic test_table_and_ops();
        send_item(OP_TEXT, 7'd0, '0);
        send_item(OP_UNUSED, 7'h55, {$urandom, $urandom});
        send_item(OP_WRITE, 7'd0, '1);
        send_item(OP_WRITE, 7'd127, 64'h1);
        send_item(OP_WRITE, 7'h2a, 64'h8000_0000_0000_0000);
        send_item(OP_TEXT, 7'd0, '0);
        send_item(OP_TEXT, 7'd127, '1);
        send_item(OP_RESTART, 7'd127, '1);
        send_item(OP_TEXT, 7'h2a, '0);
        cfg_write(REG_MAX_ERRORS, 7'd15);
        cfg_write(REG_PATTERN_LENGTH, 7'd0);
        send_item(OP_TEXT, 7'd0, '0);
        cfg_write(REG_MAX_ERRORS, 7'd8);
        cfg_write(REG_PATTERN_LENGTH, 7'd64);
        cfg_write(REG_UNUSED, 7'h7f);
        send_item(OP_TEXT, 7'h2a, '0);
        cfg_write(REG_PATTERN_LENGTH, 7'd127);
        send_item(OP_TEXT, 7'h2a, '0);
    endtask

    task automatic test_edit_operations();
        cfg_write(REG_MAX_ERRORS, 7'd0);
        cfg_write(REG_PATTERN_LENGTH, 7'd3);
        send_item(OP_WRITE, SYM_W'("a"), 64'h1);
        send_item(OP_WRITE, SYM_W'("b"), 64'h2);
        send_item(OP_WRITE, SYM_W'("c"), 64'h4);
        send_item(OP_TEXT, SYM_W'("a"), '0);
        send_item(OP_TEXT, SYM_W'("b"), '0);
        send_item(OP_TEXT, SYM_W'("c"), '0);
        cfg_write(REG_MAX_ERRORS, 7'd1);
        send_item(OP_TEXT, SYM_W'("a"), '0);
        send_item(OP_TEXT, SYM_W'("x"), '0);
        send_item(OP_TEXT, SYM_W'("c"), '0);
        send_item(OP_TEXT, SYM_W'("a"), '0);
        send_item(OP_TEXT, SYM_W'("c"), '0);
        send_item(OP_TEXT, SYM_W'("a"), '0);
        send_item(OP_TEXT, SYM_W'("b"), '0);
        send_item(OP_TEXT, SYM_W'("x"), '0);
        send_item(OP_TEXT, SYM_W'("c"), '0);
    endtask

    task automatic test_random_text();
        int               phase;
        logic [CDATA_W-1:0] err_val;
        logic [CDATA_W-1:0] len_val;
        phase = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin err_val = 7'd0;   len_val = 7'd1;   end
                1: begin err_val = 7'd8;   len_val = 7'd64;  end
                2: begin err_val = 7'd15;  len_val = 7'd127; end
                3: begin err_val = 7'd0;   len_val = 7'd0;   end
                4: begin err_val = 7'd127; len_val = 7'd65;  end
                default: begin
                    err_val = CDATA_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                                   : $urandom_range(0, 127));
                    len_val = CDATA_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 12)
                                                                   : $urandom_range(0, 127));
                end
            endcase
            cfg_write(REG_MAX_ERRORS, err_val);
            cfg_write(REG_PATTERN_LENGTH, len_val);
            load_pattern(eff_length(len_val));
            if ($urandom_range(0, 3) != 0)
                send_item(OP_RESTART, SYM_W'($urandom), {$urandom, $urandom});
            repeat ($urandom_range(40, 120)) random_item();
            phase++;
        end
    endtask

    task automatic test_backpressure();
        cfg_write(REG_MAX_ERRORS, 7'd1);
        cfg_write(REG_PATTERN_LENGTH, 7'd5);
        load_pattern(5);
        send_item(OP_RESTART, 7'd0, '0);
        tx_idle = 1'b0;
        rx_hold = 400;
        repeat (60) send_item(OP_TEXT, next_text_symbol(), {$urandom, $urandom});
        tx_idle = 1'b1;
        wait_idle();
        repeat (40) random_item();
    endtask

    task automatic test_steady_stream();
        cfg_write(REG_MAX_ERRORS, 7'd2);
        cfg_write(REG_PATTERN_LENGTH, 7'd6);
        load_pattern(6);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (100) send_item(OP_TEXT, next_text_symbol(), {$urandom, $urandom});
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
            if (rx_idle && $urandom_range(0, 99) < 30) rx_stall = idle_gap();
        end
    end

    always @(posedge aclk) begin : check_results
        match_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_matches.size() == 0) begin
                $error("unexpected result transfer: match_position %0d match_count %0d",
                       m_tdata[31:0], m_tdata[63:32]);
                fail_count++;
            end else begin
                want = predicted_matches.pop_front();
                if (m_tuser !== want.found) begin
                    $error("match_found: expected %0d, actual %0d", want.found, m_tuser);
                    fail_count++;
                end
                if (m_tdata[31:0] !== want.position) begin
                    $error("match_position: expected %0d, actual %0d",
                           want.position, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.count) begin
                    $error("match_count: expected %0d, actual %0d",
                           want.count, m_tdata[63:32]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        foreach (sym_table[i]) sym_table[i] = '0;
        clear_text();
        err_limit   = '0;
        pat_len_reg = 7'd1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_and_ops();
        test_edit_operations();
        test_random_text();
        test_backpressure();
        test_steady_stream();
        wait_idle();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
